[hdl/edid_detailed_timing_decode_defines.svh]
// ----------------------------------------------------------------------------
// EDID detailed timing decode - assertion macros
// Concurrent assertion forms for the decoder top level.
// ----------------------------------------------------------------------------
`ifndef EDID_DETAILED_TIMING_DECODE_DEFINES_SVH
`define EDID_DETAILED_TIMING_DECODE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("edt assertion failed");

// Implication with a fixed delay in cycles.
`define EDT_ASSERT_DELAY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("edt latency assertion failed");

`endif

[hdl/edt_pkg.sv]
// ----------------------------------------------------------------------------
// EDID detailed timing decode - package
// Widths, codes and payload types shared by the decoder modules.
// ----------------------------------------------------------------------------
package edt_pkg;

  // Field widths
  localparam int unsigned ActW    = 12;
  localparam int unsigned SumW    = 13;
  localparam int unsigned ClkW    = 16;
  localparam int unsigned RefW    = 10;
  localparam int unsigned ScaleW  = 14;
  localparam int unsigned FrameW  = 2 * SumW;
  localparam int unsigned HzW     = ClkW + ScaleW;
  localparam int unsigned NumW    = HzW + 1;
  localparam int unsigned CmpW    = FrameW + RefW;

  // Divider layout: quotient bits resolved per stage
  localparam int unsigned DivBits   = 2;
  localparam int unsigned DivStages = RefW / DivBits;
  // unpack, multiply, numerator prep, then the divide stages
  localparam int unsigned Latency   = 3 + DivStages;

  // 10 kHz units to Hz
  localparam logic [ScaleW-1:0] ClkScale   = 14'd10000;
  localparam logic [RefW-1:0]   RefreshMax = '1;

  // Status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusStereo    = 2'd1;
  localparam logic [1:0] StatusZeroTotal = 2'd2;

  // Sync type code for digital separate sync
  localparam logic [1:0] SyncDigitalSep  = 2'b11;

  // Stereo code for a plain, non-stereo mode
  localparam logic [1:0] StereoNone      = 2'b00;

  typedef struct packed {
    logic [15:0] pixel_clock_raw;
    logic [23:0] horiz_bytes;
    logic [23:0] vert_bytes;
    logic [31:0] sync_bytes;
    logic [7:0]  feature_byte;
  } edt_item_t;

  typedef struct packed {
    logic [ActW-1:0] h_active;
    logic [ActW-1:0] v_active;
    logic [SumW-1:0] h_total;
    logic [SumW-1:0] h_sync_start;
    logic [SumW-1:0] h_sync_end;
    logic [SumW-1:0] v_total;
    logic [SumW-1:0] v_sync_start;
    logic [SumW-1:0] v_sync_end;
    logic [ClkW-1:0] pixel_clock_10khz;
    logic [RefW-1:0] refresh_hz;
    logic [3:0]      mode_flags;
    logic [1:0]      status;
  } edt_result_t;

  // Decoded timing travelling down the pipe beside the rate math
  typedef struct packed {
    logic [ActW-1:0] h_active;
    logic [ActW-1:0] v_active;
    logic [SumW-1:0] h_total;
    logic [SumW-1:0] h_sync_start;
    logic [SumW-1:0] h_sync_end;
    logic [SumW-1:0] v_total;
    logic [SumW-1:0] v_sync_start;
    logic [SumW-1:0] v_sync_end;
    logic [ClkW-1:0] pixel_clock_10khz;
    logic [3:0]      mode_flags;
    logic [1:0]      status;
    logic            rate_en;
  } edt_timing_t;

endpackage

[hdl/edt_unpack.sv]
// ----------------------------------------------------------------------------
// EDID detailed timing decode - unpack stage
// Splits the descriptor bytes into counts and forms totals and sync edges.
// ----------------------------------------------------------------------------
module edt_unpack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  edt_pkg::edt_item_t  item_i,
  output logic                valid_o,
  output edt_pkg::edt_timing_t timing_o
);
  import edt_pkg::*;

  logic [7:0]      b2, b3, b4, b5, b6, b7, b8, b9, b10, b11, feat;
  logic [ActW-1:0] hact, hblk, vact, vblk;
  logic [9:0]      hoff, hwid;
  logic [5:0]      voff, vwid;
  logic            stereo, sep_sync, zero_tot;
  edt_timing_t     timing_d, timing_q;
  logic            valid_q;

  // byte slicing
  assign b2   = item_i.horiz_bytes[7:0];
  assign b3   = item_i.horiz_bytes[15:8];
  assign b4   = item_i.horiz_bytes[23:16];
  assign b5   = item_i.vert_bytes[7:0];
  assign b6   = item_i.vert_bytes[15:8];
  assign b7   = item_i.vert_bytes[23:16];
  assign b8   = item_i.sync_bytes[7:0];
  assign b9   = item_i.sync_bytes[15:8];
  assign b10  = item_i.sync_bytes[23:16];
  assign b11  = item_i.sync_bytes[31:24];
  assign feat = item_i.feature_byte;

  // 12-bit counts, split offsets and widths
  assign hact = {b4[7:4], b2};
  assign hblk = {b4[3:0], b3};
  assign vact = {b7[7:4], b5};
  assign vblk = {b7[3:0], b6};
  assign hoff = {b11[7:6], b8};
  assign hwid = {b11[5:4], b9};
  assign voff = {b11[3:2], b10[7:4]};
  assign vwid = {b11[1:0], b10[3:0]};

  assign stereo   = feat[6] | feat[5];
  assign sep_sync = (feat[4:3] == SyncDigitalSep) && !stereo;

  // totals, sync edges, flags and status
  always_comb begin
    timing_d.h_active          = hact;
    timing_d.v_active          = vact;
    timing_d.h_total           = SumW'(hact) + SumW'(hblk);
    timing_d.h_sync_start      = SumW'(hact) + SumW'(hoff);
    timing_d.h_sync_end        = SumW'(hact) + SumW'(hoff) + SumW'(hwid);
    timing_d.v_total           = SumW'(vact) + SumW'(vblk);
    timing_d.v_sync_start      = SumW'(vact) + SumW'(voff);
    timing_d.v_sync_end        = SumW'(vact) + SumW'(voff) + SumW'(vwid);
    timing_d.pixel_clock_10khz = item_i.pixel_clock_raw;
    timing_d.mode_flags        = {sep_sync & feat[2], sep_sync & feat[1], sep_sync, feat[7]};
    zero_tot = (timing_d.h_total == '0) || (timing_d.v_total == '0);
    if (stereo) begin
      timing_d.status = StatusStereo;
    end else if (zero_tot) begin
      timing_d.status = StatusZeroTotal;
    end else begin
      timing_d.status = StatusOk;
    end
    timing_d.rate_en = !stereo && !zero_tot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    timing_q <= timing_d;
  end

  assign valid_o  = valid_q;
  assign timing_o = timing_q;

endmodule

[hdl/edt_mul.sv]
// ----------------------------------------------------------------------------
// EDID detailed timing decode - multiply stage
// Forms the frame total and the pixel clock in hertz.
// ----------------------------------------------------------------------------
module edt_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  edt_pkg::edt_timing_t        timing_i,
  output logic                        valid_o,
  output edt_pkg::edt_timing_t        timing_o,
  output logic [edt_pkg::FrameW-1:0]  frame_o,
  output logic [edt_pkg::HzW-1:0]     hz_o
);
  import edt_pkg::*;

  logic              valid_q;
  edt_timing_t       timing_q;
  logic [FrameW-1:0] frame_d, frame_q;
  logic [HzW-1:0]    hz_d, hz_q;

  // two independent products, registered
  assign frame_d = FrameW'(timing_i.h_total) * FrameW'(timing_i.v_total);
  assign hz_d    = HzW'(timing_i.pixel_clock_10khz) * HzW'(ClkScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    timing_q <= timing_i;
    frame_q  <= frame_d;
    hz_q     <= hz_d;
  end

  assign valid_o  = valid_q;
  assign timing_o = timing_q;
  assign frame_o  = frame_q;
  assign hz_o     = hz_q;

endmodule

[hdl/edt_div.sv]
// ----------------------------------------------------------------------------
// EDID detailed timing decode - refresh divider
// Rounded, saturating refresh quotient by a pipelined restoring divider.
// ----------------------------------------------------------------------------
module edt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  edt_pkg::edt_timing_t        timing_i,
  input  logic [edt_pkg::FrameW-1:0]  frame_i,
  input  logic [edt_pkg::HzW-1:0]     hz_i,
  output logic                        done_o,
  output edt_pkg::edt_result_t        result_o
);
  import edt_pkg::*;

  logic [NumW-1:0]   num_d;
  logic              sat_d;

  // stage 0 is the numerator prep, stages 1..DivStages divide
  logic              valid_q  [DivStages+1];
  logic              sat_q    [DivStages+1];
  edt_timing_t       timing_q [DivStages+1];
  logic [NumW-1:0]   rem_q    [DivStages];
  logic [FrameW-1:0] frame_q  [DivStages];
  logic [RefW-1:0]   quo_q    [1:DivStages];
  logic [RefW-1:0]   refresh;
  edt_timing_t       tl;

  // rounding numerator and overflow check against frame * 2^RefW
  assign num_d = NumW'(hz_i) + NumW'(frame_i >> 1);
  assign sat_d = CmpW'(num_d) >= {frame_i, {RefW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q[0]    <= sat_d;
    timing_q[0] <= timing_i;
    rem_q[0]    <= num_d;
    frame_q[0]  <= frame_i;
  end

  // divide stages, DivBits quotient bits each, MSB first
  for (genvar s = 1; s <= DivStages; s++) begin : g_stage
    logic [NumW-1:0] rem_c [DivBits+1];
    logic [RefW-1:0] quo_c [DivBits+1];

    assign rem_c[0] = rem_q[s-1];
    if (s == 1) begin : g_first
      assign quo_c[0] = '0;
    end else begin : g_next
      assign quo_c[0] = quo_q[s-1];
    end

    for (genvar b = 0; b < DivBits; b++) begin : g_bit
      localparam int unsigned K = RefW - 1 - (s - 1) * DivBits - b;
      logic [CmpW-1:0] dvs;
      logic            fits;
      assign dvs        = CmpW'(frame_q[s-1]) << K;
      assign fits       = CmpW'(rem_c[b]) >= dvs;
      assign rem_c[b+1] = fits ? NumW'(CmpW'(rem_c[b]) - dvs) : rem_c[b];
      assign quo_c[b+1] = {quo_c[b][RefW-2:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      sat_q[s]    <= sat_q[s-1];
      timing_q[s] <= timing_q[s-1];
      quo_q[s]    <= quo_c[DivBits];
    end

    if (s < DivStages) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s]   <= rem_c[DivBits];
        frame_q[s] <= frame_q[s-1];
      end
    end
  end

  // result assembly: saturate, blank for stereo or zero total
  assign tl = timing_q[DivStages];
  always_comb begin
    if (!tl.rate_en) begin
      refresh = '0;
    end else if (sat_q[DivStages]) begin
      refresh = RefreshMax;
    end else begin
      refresh = quo_q[DivStages];
    end
  end

  always_comb begin
    result_o.h_active          = tl.h_active;
    result_o.v_active          = tl.v_active;
    result_o.h_total           = tl.h_total;
    result_o.h_sync_start      = tl.h_sync_start;
    result_o.h_sync_end        = tl.h_sync_end;
    result_o.v_total           = tl.v_total;
    result_o.v_sync_start      = tl.v_sync_start;
    result_o.v_sync_end        = tl.v_sync_end;
    result_o.pixel_clock_10khz = tl.pixel_clock_10khz;
    result_o.refresh_hz        = refresh;
    result_o.mode_flags        = tl.mode_flags;
    result_o.status            = tl.status;
  end

  assign done_o = valid_q[DivStages];

endmodule

[hdl/edid_detailed_timing_decode.sv]
// ----------------------------------------------------------------------------
// EDID detailed timing decode - top level
// Decodes one detailed timing descriptor per cycle into timing and refresh.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i with the used descriptor bytes and pulse start. A descriptor
//   transfers on every rising edge where start is high and busy is low; busy
//   is held low, so a new descriptor may follow in every cycle.
//   The decoded result appears on result_o for exactly one cycle, marked by
//   done_o, once the accepted descriptor has passed every stage register.
//   Throughput is one descriptor per cycle. The depth is set by the unpack
//   stage, the multiply stage, the numerator stage and five restoring divide
//   stages of two quotient bits each.
//   The receiver cannot hold results off; every result must be taken in the
//   cycle that done_o is high.
//   Reset (rst_ni low, asynchronous) clears all valid bits: descriptors in
//   flight are dropped and no done_o strobe follows from them.
// ----------------------------------------------------------------------------
`include "edid_detailed_timing_decode_defines.svh"

module edid_detailed_timing_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  edt_pkg::edt_item_t   item_i,
  output logic                 done_o,
  output edt_pkg::edt_result_t result_o
);
  import edt_pkg::*;

  logic              accept;
  logic              unp_valid, mul_valid;
  edt_timing_t       unp_timing, mul_timing;
  logic [FrameW-1:0] frame;
  logic [HzW-1:0]    hz;

  // pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  edt_unpack u_unpack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .item_i   (item_i),
    .valid_o  (unp_valid),
    .timing_o (unp_timing)
  );

  edt_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (unp_valid),
    .timing_i (unp_timing),
    .valid_o  (mul_valid),
    .timing_o (mul_timing),
    .frame_o  (frame),
    .hz_o     (hz)
  );

  edt_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .timing_i (mul_timing),
    .frame_i  (frame),
    .hz_i     (hz),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // every transfer in gives a result after the full pipe depth
  `EDT_ASSERT_DELAY(a_latency, clk_i, rst_ni, accept, 8, done_o)
  // stereo or zero total never carries a refresh value
  `EDT_ASSERT_IMPL(a_rate_blank, clk_i, rst_ni, done_o && (result_o.status != StatusOk), result_o.refresh_hz == '0)
  // stereo suppresses all polarity bits
  `EDT_ASSERT_IMPL(a_stereo_pol, clk_i, rst_ni, done_o && (result_o.status == StatusStereo), result_o.mode_flags[3:1] == 3'b000)
  // a zero total outside stereo must be flagged
  `EDT_ASSERT_IMPL(a_zero_total, clk_i, rst_ni, done_o && (result_o.status != StatusStereo) && ((result_o.h_total == '0) || (result_o.v_total == '0)), result_o.status == StatusZeroTotal)

endmodule
